// ===== hdl/sfas_pkg.sv =====
package sfas_pkg;

    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned POS_W        = 17;

    localparam logic [POS_W-1:0] POS_MAX    = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_HEADER = 17'(HEADER_BYTES);
    localparam logic [31:0]      FP_XOR     = 32'h5354554E;
    localparam logic [31:0]      CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0]      CRC_INIT   = 32'hFFFFFFFF;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPLETE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TYPE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FINGERPRINT_TYPE = 2'd2;

    localparam logic [15:0] RST_SEARCH_TYPE      = 16'd8;
    localparam logic [15:0] RST_FINGERPRINT_TYPE = 16'h8028;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0]      fingerprint_value;
        logic [POS_W-1:0] search_offset;
        logic [POS_W-1:0] fingerprint_offset;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [POS_W-1:0] pos;
    } t_q_item;

    typedef struct packed {
        logic        complete_mode;
        logic [15:0] search_type;
        logic [15:0] fingerprint_type;
    } t_cfg;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/stun_fingerprint_attr_scan_core.sv =====
// STUN message scanner: FINGERPRINT CRC-32 and attribute offset search.
// Input channel: one message byte per transfer (data_byte, last_byte), with
// i_in_valid / o_in_stall. Output channel: one result per message on the
// transfer after the byte marked last_byte, with o_out_valid / i_out_stall.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_wdata; write only while idle.
// Throughput: one byte per cycle while the queue is not full, set by the
// byte-wide CRC step and the attribute header compare/add in the back end.
// Timing: the last byte is written into the queue, and the result is
// registered when the back end pops it, after any bytes waiting ahead of it.
// A front end counts byte positions and pushes bytes into a DEPTH-entry queue;
// the back end walks the header and attributes and runs the CRC.
// When the receiver stalls, the result is held in the output register and the
// back end keeps consuming bytes until it reaches the next last byte; the
// queue then fills and o_in_stall rises.
// Reset (synchronous, active low) empties the queue, drops any pending result,
// clears the per-message state and restores the register defaults.
module stun_fingerprint_attr_scan_core #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sfas_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sfas_pkg::t_out_item               o_out,
    input  logic                              i_cfg_we,
    input  logic [sfas_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sfas_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    sfas_pkg::t_cfg    r_cfg;
    sfas_pkg::t_q_item w_push_item;
    sfas_pkg::t_q_item w_pop_item;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.complete_mode    <= 1'b1;
            r_cfg.search_type      <= sfas_pkg::RST_SEARCH_TYPE;
            r_cfg.fingerprint_type <= sfas_pkg::RST_FINGERPRINT_TYPE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfas_pkg::CFG_COMPLETE_MODE:    r_cfg.complete_mode    <= i_cfg_wdata[0];
                sfas_pkg::CFG_SEARCH_TYPE:      r_cfg.search_type      <= i_cfg_wdata;
                sfas_pkg::CFG_FINGERPRINT_TYPE: r_cfg.fingerprint_type <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    sfas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    sfas_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_pop_item)
    );

    sfas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_pop_item),
        .o_q_pop     (w_pop),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
        else $error("queue pushed while full");

    a_search_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.search_offset != '0) |->
        (o_out.search_offset >= sfas_pkg::POS_HEADER))
        else $error("search offset inside header");

    a_fp_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.fingerprint_offset != '0) |->
        (o_out.fingerprint_offset >= sfas_pkg::POS_HEADER))
        else $error("fingerprint offset inside header");

endmodule

// ===== hdl/sfas_front.sv =====
module sfas_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sfas_pkg::t_in_item i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output sfas_pkg::t_q_item o_item
);

    logic [sfas_pkg::POS_W-1:0] r_pos;
    logic [sfas_pkg::POS_W-1:0] n_pos;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_item.data_byte = i_in.data_byte;
        o_item.last_byte = i_in.last_byte;
        o_item.pos       = r_pos;
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_in.last_byte) begin
                n_pos = '0;
            end else if (r_pos != sfas_pkg::POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== hdl/sfas_queue.sv =====
module sfas_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfas_pkg::t_q_item i_item,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output sfas_pkg::t_q_item o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sfas_pkg::t_q_item r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/sfas_back.sv =====
module sfas_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  sfas_pkg::t_q_item  i_q_item,
    output logic               o_q_pop,
    input  sfas_pkg::t_cfg     i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sfas_pkg::t_out_item o_out
);

    localparam int unsigned PW = sfas_pkg::POS_W;

    logic [15:0]   r_hdr_len,  n_hdr_len;
    logic [PW-1:0] r_nas,      n_nas;
    logic [23:0]   r_shift,    n_shift;
    logic          r_walk,     n_walk;
    logic [31:0]   r_crc,      n_crc;
    logic          r_frozen,   n_frozen;
    logic [31:0]   r_att_crc,  n_att_crc;
    logic [PW-1:0] r_found_s,  n_found_s;
    logic [PW-1:0] r_found_f,  n_found_f;
    logic          r_out_valid, n_out_valid;
    sfas_pkg::t_out_item r_out, n_out;

    logic [PW-1:0] w_pos;
    logic [7:0]    w_b;
    logic          w_start;
    logic          w_walk;
    logic          w_hdr_done;
    logic [31:0]   w_hdr;
    logic [PW-1:0] w_pad;
    logic [PW:0]   w_next;

    assign w_pos = i_q_item.pos;
    assign w_b   = i_q_item.data_byte;

    assign o_q_pop = i_q_valid && (!i_q_item.last_byte || !r_out_valid || !i_out_stall);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_hdr_len = r_hdr_len;
        if (w_pos == PW'(2)) begin
            n_hdr_len = {w_b, r_hdr_len[7:0]};
        end else if (w_pos == PW'(3)) begin
            n_hdr_len = {r_hdr_len[15:8], w_b};
        end

        w_start = !r_walk && (w_pos == r_nas) && (w_pos >= sfas_pkg::POS_HEADER) &&
                  ((w_pos - sfas_pkg::POS_HEADER) < {1'b0, r_hdr_len});
        w_walk  = r_walk || w_start;

        n_att_crc = w_start ? r_crc : r_att_crc;
        n_crc     = r_frozen ? r_crc : sfas_pkg::crc_byte(r_crc, w_b);
        n_frozen  = r_frozen;
        n_walk    = w_walk;
        n_shift   = r_shift;
        n_nas     = r_nas;
        n_found_s = r_found_s;
        n_found_f = r_found_f;

        w_hdr      = {r_shift, w_b};
        w_hdr_done = w_walk && ((w_pos - r_nas) >= PW'(3));
        w_pad      = (PW'({1'b0, w_hdr[15:0]}) + PW'(3)) & ~PW'(3);
        w_next     = {1'b0, r_nas} + (PW+1)'(4) + {1'b0, w_pad};

        if (w_walk) begin
            n_shift = w_hdr[23:0];
            if (w_hdr_done) begin
                if (w_hdr[31:16] == i_cfg.search_type && r_found_s == '0) begin
                    n_found_s = r_nas;
                end
                if (w_hdr[31:16] == i_cfg.fingerprint_type && r_found_f == '0) begin
                    n_found_f = r_nas;
                    if (i_cfg.complete_mode && !r_frozen) begin
                        n_crc    = n_att_crc;
                        n_frozen = 1'b1;
                    end
                end
                n_nas  = w_next[PW] ? sfas_pkg::POS_MAX : w_next[PW-1:0];
                n_walk = 1'b0;
            end
        end

        n_out = r_out;
        if (i_cfg.complete_mode && n_found_f == '0) begin
            n_out.fingerprint_value = sfas_pkg::FP_XOR;
        end else begin
            n_out.fingerprint_value = ~n_crc ^ sfas_pkg::FP_XOR;
        end
        n_out.search_offset      = n_found_s;
        n_out.fingerprint_offset = n_found_f;

        n_out_valid = r_out_valid && i_out_stall;
        if (o_q_pop && i_q_item.last_byte) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.last_byte) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len   <= '0;
            r_nas       <= sfas_pkg::POS_HEADER;
            r_shift     <= '0;
            r_walk      <= 1'b0;
            r_crc       <= sfas_pkg::CRC_INIT;
            r_frozen    <= 1'b0;
            r_att_crc   <= sfas_pkg::CRC_INIT;
            r_found_s   <= '0;
            r_found_f   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_q_pop) begin
                if (i_q_item.last_byte) begin
                    r_hdr_len <= '0;
                    r_nas     <= sfas_pkg::POS_HEADER;
                    r_shift   <= '0;
                    r_walk    <= 1'b0;
                    r_crc     <= sfas_pkg::CRC_INIT;
                    r_frozen  <= 1'b0;
                    r_att_crc <= sfas_pkg::CRC_INIT;
                    r_found_s <= '0;
                    r_found_f <= '0;
                end else begin
                    r_hdr_len <= n_hdr_len;
                    r_nas     <= n_nas;
                    r_shift   <= n_shift;
                    r_walk    <= n_walk;
                    r_crc     <= n_crc;
                    r_frozen  <= n_frozen;
                    r_att_crc <= n_att_crc;
                    r_found_s <= n_found_s;
                    r_found_f <= n_found_f;
                end
            end
        end
    end

endmodule
